@@ rtl/otq_pkg.sv @@
// package: types, codes and helpers for the ordered timeout queue
`timescale 1ns / 1ps
package otq_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam logic [1:0] OP_ADD_ONESHOT  = 2'd0;
  localparam logic [1:0] OP_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] OP_SERVICE      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] now;
    logic [63:0] delay;
    logic [7:0]  handle;
  } otq_cmd_t;

  typedef struct packed {
    logic        fired;
    logic [7:0]  fired_handle;
    logic        spurious;
    logic        dropped;
    logic        has_next;
    logic [63:0] next_due;
  } otq_result_t;

  typedef struct packed {
    logic [63:0] due;
    logic        periodic;
    logic [63:0] period;
    logic [7:0]  handle;
  } otq_slot_t;

  typedef struct packed {
    logic shift;
    logic insert;
  } otq_ctl_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

@@ rtl/otq_cell.sv @@
// one queue cell: holds a slot, shifts toward the head or opens a gap on insert
`timescale 1ns / 1ps
module otq_cell (
  input  logic              clk,
  input  logic              rst,
  input  otq_pkg::otq_ctl_t  ctl,
  input  otq_pkg::otq_slot_t key,
  input  otq_pkg::otq_slot_t left_slot,
  input  logic              left_vld,
  input  logic              left_ins,
  input  otq_pkg::otq_slot_t right_slot,
  input  logic              right_vld,
  output otq_pkg::otq_slot_t slot,
  output logic              vld,
  output logic              ins_here
);
  import otq_pkg::*;

  assign ins_here = !vld || (slot.due >= key.due);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.shift) begin
      vld <= right_vld;
    end else if (ctl.insert) begin
      if (left_ins) begin
        vld <= left_vld;
      end else if (ins_here) begin
        vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot <= right_slot;
    end else if (ctl.insert) begin
      if (left_ins) begin
        slot <= left_slot;
      end else if (ins_here) begin
        slot <= key;
      end
    end
  end

endmodule

@@ rtl/ordered_timeout_queue_top.sv @@
// top level: command sequencer and the row of sorted queue cells
//
// Usage: raise start with a command on cmd while busy is low; the command is
// taken at that clock edge. op selects add one-shot, add periodic or service.
// Exactly one result follows per command, shown on result for one cycle while
// done is high; the receiver cannot stall it and must take it in that cycle.
// A dropped add, a service that fires a one-shot entry, a spurious service or
// an unused op goes straight from idle to done; an add that is stored or a
// service that reloads a periodic entry passes through the insert state first.
// busy stays high through the done cycle, so one command is in flight at a
// time and no new command is taken before idle. The cost is set by the cell
// row: every cell compares its due time against the new key in parallel and
// the whole row shifts at once, so the depth does not enter the latency.
// Reset clears all valid bits (empty queue) and returns the sequencer to idle.
`timescale 1ns / 1ps
module ordered_timeout_queue_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  otq_pkg::otq_cmd_t    cmd,
  output logic                busy,
  output logic                done,
  output otq_pkg::otq_result_t result
);
  import otq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  otq_slot_t key;
  logic      fired;
  logic [7:0] fired_handle;
  logic      spurious;
  logic      dropped;

  otq_ctl_t  ctl;
  otq_slot_t slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld;
  logic [QUEUE_DEPTH-1:0] ins;

  logic accept;
  logic head_due;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign head_due = vld[0] && (slot[0].due <= cmd.now);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DONE;
          case (cmd.op)
            OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
              if (!vld[QUEUE_DEPTH-1]) begin
                state_next = ST_INS;
              end
            end
            OP_SERVICE: begin
              if (head_due) begin
                ctl.shift = 1'b1;
                if (slot[0].periodic) begin
                  state_next = ST_INS;
                end
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_INS: begin
        ctl.insert = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (cmd.op)
        OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
          fired        <= 1'b0;
          fired_handle <= '0;
          spurious     <= 1'b0;
          dropped      <= vld[QUEUE_DEPTH-1];
          key.due      <= sat_add(cmd.now, cmd.delay);
          key.periodic <= (cmd.op == OP_ADD_PERIODIC);
          key.period   <= (cmd.op == OP_ADD_PERIODIC) ? cmd.delay : '0;
          key.handle   <= cmd.handle;
        end
        OP_SERVICE: begin
          fired        <= head_due;
          fired_handle <= head_due ? slot[0].handle : '0;
          spurious     <= !head_due;
          dropped      <= 1'b0;
          if (head_due) begin
            key.due      <= sat_add(slot[0].due, slot[0].period);
            key.periodic <= 1'b1;
            key.period   <= slot[0].period;
            key.handle   <= slot[0].handle;
          end
        end
        default: begin
          fired        <= 1'b0;
          fired_handle <= '0;
          spurious     <= 1'b0;
          dropped      <= 1'b0;
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      otq_slot_t left_slot;
      logic      left_vld;
      logic      left_ins;
      otq_slot_t right_slot;
      logic      right_vld;

      if (gi == 0) begin : g_first
        assign left_slot = '0;
        assign left_vld  = 1'b0;
        assign left_ins  = 1'b0;
      end else begin : g_mid
        assign left_slot = slot[gi-1];
        assign left_vld  = vld[gi-1];
        assign left_ins  = ins[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_slot = '0;
        assign right_vld  = 1'b0;
      end else begin : g_inner
        assign right_slot = slot[gi+1];
        assign right_vld  = vld[gi+1];
      end

      otq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .key        (key),
        .left_slot  (left_slot),
        .left_vld   (left_vld),
        .left_ins   (left_ins),
        .right_slot (right_slot),
        .right_vld  (right_vld),
        .slot       (slot[gi]),
        .vld        (vld[gi]),
        .ins_here   (ins[gi])
      );
    end
  endgenerate

  always_comb begin
    result.fired        = fired;
    result.fired_handle = fired_handle;
    result.spurious     = spurious;
    result.dropped      = dropped;
    result.has_next     = vld[0];
    result.next_due     = vld[0] ? slot[0].due : '0;
  end

`ifndef SYNTHESIS
  // occupied cells always form one run starting at the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (vld & (vld + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1})) == '0)
    else $error("queue cells not contiguous");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && vld[1]) |-> (slot[0].due <= slot[1].due))
    else $error("queue head out of order");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> !(fired && spurious) && !(dropped && (fired || spurious)))
    else $error("conflicting result flags");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result repeated or sequencer stuck");

  a_no_shift_insert: assert property (@(posedge clk) disable iff (rst)
    !(ctl.shift && ctl.insert))
    else $error("shift and insert together");
`endif

endmodule
